@@ hw/rtl/uest_pkg.sv @@
// shared types and constants for the unique element set table
// used by uest_ctrl, uest_dp and unique_element_set_table
package uest_pkg;

    localparam int CAPACITY_DEF     = 16;
    localparam int ELEMENT_BITS_DEF = 32;
    localparam int IN_ELEM_W        = 32;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_PRESENT = 2'd1,
        ST_FULL    = 2'd2,
        ST_ABSENT  = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
    } t_ctrl;

    // datapath to controller
    typedef struct packed {
        logic out_busy;
    } t_dp_stat;

endpackage

@@ hw/rtl/unique_element_set_table.sv @@
// unique element set table: packed set of unique elements in arrival order
// a word is accepted in the idle state and worked in the exec state, where all
// cells are compared and compacted at once and the result register is written;
// the two-state sequencer takes no new request until that work is done; a
// result word not yet taken by the sink delays the work until it leaves
// reset clears the count and the result valid flag; entries are left unwritten
module unique_element_set_table #(
    parameter int CAPACITY     = uest_pkg::CAPACITY_DEF,
    parameter int ELEMENT_BITS = uest_pkg::ELEMENT_BITS_DEF,
    parameter int CNT_W        = $clog2(CAPACITY + 1)
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [1:0]                            i_cmd,
    input  logic signed [uest_pkg::IN_ELEM_W-1:0] i_element,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [1:0]                            o_status,
    output logic [CNT_W-1:0]                      o_count,
    output logic                                  o_is_full,
    output logic                                  o_is_empty
);

    uest_pkg::t_ctrl    w_ctrl;
    uest_pkg::t_dp_stat w_stat;

    uest_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl)
    );

    uest_dp #(
        .CAPACITY     (CAPACITY),
        .ELEMENT_BITS (ELEMENT_BITS),
        .CNT_W        (CNT_W)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_ctrl),
        .o_stat     (w_stat),
        .i_cmd      (i_cmd),
        .i_element  (i_element),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_status   (o_status),
        .o_count    (o_count),
        .o_is_full  (o_is_full),
        .o_is_empty (o_is_empty)
    );

    // a word in flight blocks the next one
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input taken while a word is in flight");

    // count never goes past capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_count <= CNT_W'(CAPACITY)))
        else $error("count above capacity");

    // a full table is never reported empty
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_is_full && o_is_empty))
        else $error("full and empty at once");

    // only one of load and execute per cycle
    a_ctrl_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_ctrl.load && w_ctrl.exec))
        else $error("load and execute in the same cycle");

endmodule

@@ hw/rtl/uest_ctrl.sv @@
// request sequencer for the unique element set table
// depends on uest_pkg
module uest_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  uest_pkg::t_dp_stat  i_stat,
    output uest_pkg::t_ctrl     o_ctrl
);

    uest_pkg::t_state r_state;
    uest_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= uest_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_ready     = 1'b0;
        o_ctrl.load = 1'b0;
        o_ctrl.exec = 1'b0;
        case (r_state)
            uest_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_ctrl.load = 1'b1;
                    n_state     = uest_pkg::S_EXEC;
                end
            end
            uest_pkg::S_EXEC: begin
                // wait until the result register can take the word
                if (!i_stat.out_busy) begin
                    o_ctrl.exec = 1'b1;
                    n_state     = uest_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = uest_pkg::S_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/uest_dp.sv @@
// entry cells, parallel compare, compaction and result register
// depends on uest_pkg
module uest_dp #(
    parameter int CAPACITY     = uest_pkg::CAPACITY_DEF,
    parameter int ELEMENT_BITS = uest_pkg::ELEMENT_BITS_DEF,
    parameter int CNT_W        = $clog2(CAPACITY + 1)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  uest_pkg::t_ctrl                   i_ctrl,
    output uest_pkg::t_dp_stat                o_stat,
    input  logic [1:0]                        i_cmd,
    input  logic signed [uest_pkg::IN_ELEM_W-1:0] i_element,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [1:0]                        o_status,
    output logic [CNT_W-1:0]                  o_count,
    output logic                              o_is_full,
    output logic                              o_is_empty
);

    uest_pkg::t_cmd          r_cmd;
    logic [ELEMENT_BITS-1:0] r_key;
    logic [ELEMENT_BITS-1:0] r_entries [CAPACITY];
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;
    logic                    r_out_valid;
    uest_pkg::t_status       r_status;
    uest_pkg::t_status       n_status;
    logic [CNT_W-1:0]        r_out_count;

    logic [CAPACITY-1:0]     w_match;
    logic [CAPACITY-1:0]     w_shift;
    logic                    w_hit;
    logic                    w_full;
    logic                    w_do_ins;
    logic                    w_do_rem;

    assign w_full = (r_count == CNT_W'(CAPACITY));
    assign w_hit  = |w_match;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd <= uest_pkg::t_cmd'(i_cmd);
            r_key <= ELEMENT_BITS'($unsigned(i_element));
        end
    end

    // occupied cells match the key; shift enable is the running or of matches
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        assign w_match[gi] = (r_count > CNT_W'(gi)) && (r_entries[gi] == r_key);
        assign w_shift[gi] = |w_match[gi:0];

        if (gi < CAPACITY - 1) begin : g_mid
            always_ff @(posedge i_clk) begin
                if (i_ctrl.exec) begin
                    if (w_do_ins && (r_count == CNT_W'(gi))) begin
                        r_entries[gi] <= r_key;
                    end else if (w_do_rem && w_shift[gi]) begin
                        r_entries[gi] <= r_entries[gi+1];
                    end
                end
            end
        end else begin : g_last
            always_ff @(posedge i_clk) begin
                if (i_ctrl.exec && w_do_ins && (r_count == CNT_W'(gi))) begin
                    r_entries[gi] <= r_key;
                end
            end
        end
    end

    always_comb begin
        n_count  = r_count;
        n_status = uest_pkg::ST_DONE;
        w_do_ins = 1'b0;
        w_do_rem = 1'b0;
        case (r_cmd)
            uest_pkg::CMD_INSERT: begin
                if (w_hit) begin
                    n_status = uest_pkg::ST_PRESENT;
                end else if (w_full) begin
                    n_status = uest_pkg::ST_FULL;
                end else begin
                    w_do_ins = 1'b1;
                    n_count  = r_count + CNT_W'(1);
                end
            end
            uest_pkg::CMD_REMOVE: begin
                if (w_hit) begin
                    w_do_rem = 1'b1;
                    n_count  = r_count - CNT_W'(1);
                end else begin
                    n_status = uest_pkg::ST_ABSENT;
                end
            end
            uest_pkg::CMD_QUERY: begin
                n_status = w_hit ? uest_pkg::ST_DONE : uest_pkg::ST_ABSENT;
            end
            uest_pkg::CMD_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctrl.exec) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.exec) begin
            r_status    <= n_status;
            r_out_count <= n_count;
        end
    end

    assign o_stat.out_busy = r_out_valid && !i_ready;
    assign o_valid         = r_out_valid;
    assign o_status        = r_status;
    assign o_count         = r_out_count;
    assign o_is_full       = (r_out_count == CNT_W'(CAPACITY));
    assign o_is_empty      = (r_out_count == '0);

endmodule
